// ----- hw/rtl/gmds_pkg.sv -----
// Package for the grid maze depth-first solver.
// Holds fixed sizes, opcodes, status codes, probe directions, register addresses and the sequencer state type.
// No dependencies.
`default_nettype none
package gmds_pkg;
	localparam int unsigned MAX_GRID    = 64;
	localparam int unsigned STACK_DEPTH = 4096;
	localparam int unsigned CW          = $clog2(MAX_GRID);
	localparam int unsigned CELLS       = MAX_GRID * MAX_GRID;
	localparam int unsigned AW          = $clog2(CELLS);
	localparam int unsigned SW          = $clog2(STACK_DEPTH);

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_SOLVE = 2'd1,
		OP_READ  = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_FOUND  = 2'd1,
		ST_NOPATH = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		DIR_SOUTH = 2'd0,
		DIR_EAST  = 2'd1,
		DIR_NORTH = 2'd2,
		DIR_WEST  = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_START,
		S_CHECK,
		S_PROBE,
		S_TEST,
		S_BACK,
		S_BACKRD,
		S_READRD,
		S_RESP
	} fsm_t;

	localparam logic [1:0] REG_GRID_SIZE = 2'd0;
	localparam logic [1:0] REG_EXIT      = 2'd1;
endpackage
`default_nettype wire

// ----- hw/rtl/grid_maze_dfs_solver.sv -----
// Top level of the grid maze depth-first solver: sequencer, cell, visited
// and path memories, APB register port. Depends on gmds_pkg.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_tvalid / s_tready       s_tdata: opcode, cell_x, cell_y, cell_open, path_index
// m_axis    out  m_tvalid / m_tready       m_tdata: status, path_length, path_x, path_y
// apb       in   psel, penable, pwrite     paddr 0: grid_size, 4: exit_coordinate
//
// One item at a time; s_tready is high only while the sequencer is idle.
// A solve first clears the visited memory, one cell a cycle, then runs search
// steps (exit check, up to four probes of the cell memories, push through the
// stack write port or pop through its read port). Reset clears only control
// state; cell and path memories hold no reset value. A full output register
// holds the sequencer in its response state until m_tready.
`default_nettype none
module grid_maze_dfs_solver (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// [1:0] opcode, [7:2] cell_x, [13:8] cell_y, [14] cell_open, [26:15] path_index
	input  wire  [31:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// [1:0] status, [14:2] path_length, [20:15] path_x, [26:21] path_y
	output logic [31:0] m_tdata,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gmds_pkg::*;

	localparam logic [AW-1:0] START_ADDR = AW'(MAX_GRID);  // row 1, column 0

	fsm_t          state_q, state_d;
	logic [6:0]    grid_size_q, exit_q;
	logic [CW-1:0] cur_x_q, cur_y_q;
	logic [SW:0]   count_q;
	logic [1:0]    dir_q;
	logic [AW-1:0] clr_q;
	logic [1:0]    res_status_q;
	logic [SW:0]   res_len_q;
	logic [CW-1:0] res_x_q, res_y_q;

	logic          open_mem [CELLS];
	logic          vis_mem  [CELLS];
	logic [2*CW-1:0] stk_mem [STACK_DEPTH];
	logic          open_rd_q, vis_rd_q;
	logic [2*CW-1:0] stk_rd_q;

	logic          in_xfer;
	op_t           in_op;
	logic [CW-1:0] in_x, in_y;
	logic          in_open;
	logic [SW-1:0] in_idx;

	logic [6:0]    gsz;
	logic [6:0]    nx, ny;
	logic          nb_ok;
	logic [AW-1:0] nb_addr;
	logic          at_exit, can_move;
	logic [SW-1:0] stk_raddr;

	// Memory write controls
	logic          open_we, open_wd, vis_we, vis_wd, stk_we;
	logic [AW-1:0] open_wa, vis_wa;
	logic [SW-1:0] stk_wa;
	logic [2*CW-1:0] stk_wd;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign in_op    = op_t'(s_tdata[1:0]);
	assign in_x     = s_tdata[7:2];
	assign in_y     = s_tdata[13:8];
	assign in_open  = s_tdata[14];
	assign in_idx   = s_tdata[26:15];

	// APB: pready tied high, registers readable
	assign pready = 1'b1;
	always_comb begin
		case (paddr[2])
			1'b0:    prdata = {25'd0, grid_size_q};
			default: prdata = {25'd0, exit_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= 7'd51;
			exit_q      <= 7'd50;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr == {REG_GRID_SIZE[0], 2'b00})
				grid_size_q <= pwdata[6:0];
			else if (paddr == {REG_EXIT[0], 2'b00})
				exit_q <= pwdata[6:0];
		end
	end

	// Clip the grid to the physical map
	assign gsz = (grid_size_q > 7'(MAX_GRID)) ? 7'(MAX_GRID) : grid_size_q;

	// Neighbor in the current probe direction
	always_comb begin
		nx    = {1'b0, cur_x_q};
		ny    = {1'b0, cur_y_q};
		nb_ok = 1'b1;
		case (dir_t'(dir_q))
			DIR_SOUTH: ny = {1'b0, cur_y_q} + 7'd1;
			DIR_EAST:  nx = {1'b0, cur_x_q} + 7'd1;
			DIR_NORTH: begin
				ny    = {1'b0, cur_y_q} - 7'd1;
				nb_ok = (cur_y_q != '0);
			end
			default: begin
				nx    = {1'b0, cur_x_q} - 7'd1;
				nb_ok = (cur_x_q != '0);
			end
		endcase
		nb_ok   = nb_ok && (nx < gsz) && (ny < gsz);
		nb_addr = {ny[CW-1:0], nx[CW-1:0]};
	end

	assign at_exit  = ({1'b0, cur_x_q} >= exit_q) || ({1'b0, cur_y_q} >= exit_q);
	assign can_move = open_rd_q && !vis_rd_q;

	// Next state and memory controls
	always_comb begin
		state_d   = state_q;
		open_we   = 1'b0;
		open_wa   = nb_addr;
		open_wd   = 1'b1;
		vis_we    = 1'b0;
		vis_wa    = nb_addr;
		vis_wd    = 1'b1;
		stk_we    = 1'b0;
		stk_wa    = count_q[SW-1:0];
		stk_wd    = nb_addr;
		stk_raddr = in_idx;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (in_op)
						OP_LOAD: begin
							open_we = 1'b1;
							open_wa = {in_y, in_x};
							open_wd = in_open;
							state_d = S_RESP;
						end
						OP_SOLVE: state_d = S_CLEAR;
						OP_READ: begin
							state_d = ({1'b0, in_idx} < count_q) ? S_READRD : S_RESP;
						end
						default: state_d = S_RESP;
					endcase
				end
			end
			S_CLEAR: begin
				vis_we = 1'b1;
				vis_wa = clr_q;
				vis_wd = 1'b0;
				if (clr_q == AW'(CELLS - 1))
					state_d = S_START;
			end
			S_START: begin
				// Mark the start cell seen and open, and push it
				vis_we  = 1'b1;
				vis_wa  = START_ADDR;
				open_we = 1'b1;
				open_wa = START_ADDR;
				stk_we  = 1'b1;
				stk_wa  = '0;
				stk_wd  = START_ADDR;
				state_d = S_CHECK;
			end
			S_CHECK: state_d = at_exit ? S_RESP : S_PROBE;
			S_PROBE: begin
				if (nb_ok)
					state_d = S_TEST;
				else if (dir_q == DIR_WEST)
					state_d = S_BACK;
			end
			S_TEST: begin
				if (can_move) begin
					if (count_q[SW]) begin
						state_d = S_RESP;
					end else begin
						vis_we  = 1'b1;
						stk_we  = 1'b1;
						state_d = S_CHECK;
					end
				end else if (dir_q == DIR_WEST) begin
					state_d = S_BACK;
				end else begin
					state_d = S_PROBE;
				end
			end
			S_BACK: begin
				stk_raddr = SW'(count_q - (SW+1)'(2));
				state_d   = (count_q <= (SW+1)'(1)) ? S_RESP : S_BACKRD;
			end
			S_BACKRD: state_d = S_CHECK;
			S_READRD: state_d = S_RESP;
			S_RESP: begin
				if (!m_tvalid || m_tready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (open_we)
			open_mem[open_wa] <= open_wd;
		open_rd_q <= open_mem[nb_addr];
	end

	always_ff @(posedge clk) begin
		if (vis_we)
			vis_mem[vis_wa] <= vis_wd;
		vis_rd_q <= vis_mem[nb_addr];
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[stk_wa] <= stk_wd;
		stk_rd_q <= stk_mem[stk_raddr];
	end

	// Search datapath and result capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= CW'(1);
			count_q      <= '0;
			dir_q        <= DIR_SOUTH;
			clr_q        <= '0;
			res_status_q <= ST_DONE;
			res_len_q    <= '0;
			res_x_q      <= '0;
			res_y_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					clr_q <= '0;
					if (in_xfer) begin
						res_status_q <= (in_op == OP_READ && {1'b0, in_idx} >= count_q) ?
						                ST_RANGE : ST_DONE;
						res_len_q    <= (in_op == OP_READ) ? count_q : '0;
						res_x_q      <= '0;
						res_y_q      <= '0;
					end
				end
				S_CLEAR: clr_q <= clr_q + AW'(1);
				S_START: begin
					cur_x_q <= '0;
					cur_y_q <= CW'(1);
					count_q <= (SW+1)'(1);
				end
				S_CHECK: begin
					dir_q <= DIR_SOUTH;
					if (at_exit) begin
						res_status_q <= ST_FOUND;
						res_len_q    <= count_q;
						res_x_q      <= cur_x_q;
						res_y_q      <= cur_y_q;
					end
				end
				S_PROBE: begin
					if (!nb_ok)
						dir_q <= dir_q + 2'd1;
				end
				S_TEST: begin
					if (can_move) begin
						if (count_q[SW]) begin
							count_q      <= '0;
							res_status_q <= ST_NOPATH;
						end else begin
							count_q <= count_q + (SW+1)'(1);
							cur_x_q <= nx[CW-1:0];
							cur_y_q <= ny[CW-1:0];
						end
					end else begin
						dir_q <= dir_q + 2'd1;
					end
				end
				S_BACK: begin
					if (count_q <= (SW+1)'(1)) begin
						count_q      <= '0;
						res_status_q <= ST_NOPATH;
					end else begin
						count_q <= count_q - (SW+1)'(1);
					end
				end
				S_BACKRD: begin
					cur_x_q <= stk_rd_q[CW-1:0];
					cur_y_q <= stk_rd_q[2*CW-1:CW];
				end
				S_READRD: begin
					res_x_q <= stk_rd_q[CW-1:0];
					res_y_q <= stk_rd_q[2*CW-1:CW];
				end
				default: ;
			endcase
		end
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			if (state_q == S_RESP && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {5'd0, res_y_q, res_x_q, res_len_q, res_status_q};
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
